[rtl/pelp_pkg.sv]
package pelp_pkg;

	localparam int POOL_SIZE = 64;
	localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	localparam int OP_W   = 3;
	localparam int PRI_W  = 2;
	localparam int LIFE_W = 24;
	localparam int TAG_W  = 16;
	localparam int SLOT_W = 6;
	localparam int RCNT_W = 7;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PRI_W-1:0]  new_priority;
		logic [LIFE_W-1:0] new_lifetime;
		logic [TAG_W-1:0]  new_tag;
		logic [SLOT_W-1:0] slot;
		logic [LIFE_W-1:0] elapsed;
	} pelp_cmd_t;

	typedef struct packed {
		logic              accepted;
		logic              evicted;
		logic [TAG_W-1:0]  evicted_tag;
		logic [RCNT_W-1:0] expired_count;
		logic [RCNT_W-1:0] count_after;
		logic              read_valid;
		logic [PRI_W-1:0]  read_priority;
		logic [LIFE_W-1:0] read_lifetime;
		logic [TAG_W-1:0]  read_tag;
	} pelp_res_t;

	typedef struct packed {
		logic [PRI_W-1:0]  priority_v;
		logic [LIFE_W-1:0] lifetime;
		logic [TAG_W-1:0]  tag;
	} pelp_entry_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		pelp_entry_t       wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} pelp_mem_req_t;

endpackage

[rtl/pelp_mem.sv]
module pelp_mem (
	input  logic                  clk,
	input  pelp_pkg::pelp_mem_req_t req,
	output pelp_pkg::pelp_entry_t   rdata
);
	import pelp_pkg::*;

	pelp_entry_t mem [POOL_SIZE];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[rtl/pelp_alu.sv]
module pelp_alu (
	input  logic [pelp_pkg::LIFE_W-1:0] a,
	input  logic [pelp_pkg::LIFE_W-1:0] b,
	output logic [pelp_pkg::LIFE_W-1:0] diff_sat,
	output logic                        borrow,
	output logic                        zero
);
	import pelp_pkg::*;

	logic [LIFE_W:0] full;

	// one subtractor: saturating decrement for ticks, less-than for the eviction scan
	assign full     = {1'b0, a} - {1'b0, b};
	assign borrow   = full[LIFE_W];
	assign diff_sat = borrow ? '0 : full[LIFE_W-1:0];
	assign zero     = (diff_sat == '0);

endmodule

[rtl/priority_evicting_lifetime_pool.sv]
// Channel   Handshake        Payload   Notes
// command   start / busy     cmd       word taken when start is high and busy is low
// result    done (strobe)    result    word shown for one cycle, receiver cannot stall
//
// Sequencing: add to a non-full pool, remove of the last entry, out-of-range remove or read,
// clear and unused codes end in the dispatch state; read and remove of an inner slot add a
// memory read; an add to a full pool scans from slot 0 for a lower priority, moves the last
// entry into the victim's slot and writes the new entry at the last slot, or is refused if
// none is found; a tick visits each live entry, dropping expired ones. Reset clears the live
// count and the sequencer; entry contents are left as they are. busy falls in the cycle that
// done shows, so the next word can be taken at the edge that ends it.
module priority_evicting_lifetime_pool (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pelp_pkg::pelp_cmd_t cmd,
	output logic                done,
	output pelp_pkg::pelp_res_t result
);
	import pelp_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DISP   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_EVICT  = 3'd3;
	localparam logic [2:0] ST_APPEND = 3'd4;
	localparam logic [2:0] ST_REMOVE = 3'd5;
	localparam logic [2:0] ST_TICK   = 3'd6;
	localparam logic [2:0] ST_READ   = 3'd7;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q;
	logic             fin;

	pelp_cmd_t        cmd_q;
	logic [IDX_W-1:0] i_q, i_d;
	logic [IDX_W-1:0] victim_q, victim_d;
	pelp_res_t        work_q, work_d;
	pelp_res_t        result_q;

	pelp_mem_req_t    mreq;
	pelp_entry_t      rdata;
	pelp_entry_t      new_entry;

	logic [LIFE_W-1:0] alu_a, alu_b, alu_diff;
	logic              alu_borrow, alu_zero;

	logic [IDX_W-1:0]  last;
	logic              slot_live;

	pelp_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	// the scan compares priorities, the tick decrements lifetimes: same subtractor
	assign alu_a = (state_q == ST_SCAN) ? LIFE_W'(rdata.priority_v) : rdata.lifetime;
	assign alu_b = (state_q == ST_SCAN) ? LIFE_W'(cmd_q.new_priority) : cmd_q.elapsed;

	pelp_alu u_alu (
		.a        (alu_a),
		.b        (alu_b),
		.diff_sat (alu_diff),
		.borrow   (alu_borrow),
		.zero     (alu_zero)
	);

	assign last      = IDX_W'(count_q - 1'b1);
	assign slot_live = (32'(cmd_q.slot) < 32'(count_q));
	assign new_entry = '{priority_v: cmd_q.new_priority,
	                     lifetime:   cmd_q.new_lifetime,
	                     tag:        cmd_q.new_tag};

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		i_d      = i_q;
		victim_d = victim_q;
		work_d   = work_q;
		mreq     = '0;
		fin      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					work_d  = '0;
					state_d = ST_DISP;
				end
			end

			ST_DISP: begin
				case (cmd_q.op)
					OP_ADD: begin
						if (32'(count_q) < POOL_SIZE) begin
							// room left: append at the end
							mreq.we         = 1'b1;
							mreq.waddr      = IDX_W'(count_q);
							mreq.wdata      = new_entry;
							count_d         = count_q + 1'b1;
							work_d.accepted = 1'b1;
							fin             = 1'b1;
						end else begin
							// full: hunt for the first lower priority from slot 0
							mreq.re    = 1'b1;
							mreq.raddr = '0;
							i_d        = '0;
							state_d    = ST_SCAN;
						end
					end
					OP_REMOVE: begin
						if (slot_live) begin
							work_d.accepted = 1'b1;
							if (IDX_W'(cmd_q.slot) == last) begin
								count_d = count_q - 1'b1;
								fin     = 1'b1;
							end else begin
								mreq.re    = 1'b1;
								mreq.raddr = last;
								state_d    = ST_REMOVE;
							end
						end else begin
							fin = 1'b1;
						end
					end
					OP_TICK: begin
						if (count_q == '0) begin
							fin = 1'b1;
						end else begin
							mreq.re    = 1'b1;
							mreq.raddr = '0;
							i_d        = '0;
							state_d    = ST_TICK;
						end
					end
					OP_CLEAR: begin
						count_d = '0;
						fin     = 1'b1;
					end
					OP_READ: begin
						if (slot_live) begin
							mreq.re    = 1'b1;
							mreq.raddr = IDX_W'(cmd_q.slot);
							state_d    = ST_READ;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end

			ST_SCAN: begin
				// rdata holds slot i_q; borrow means its priority is below the new one
				if (alu_borrow) begin
					work_d.evicted     = 1'b1;
					work_d.evicted_tag = rdata.tag;
					victim_d           = i_q;
					mreq.re            = 1'b1;
					mreq.raddr         = LAST_IDX;
					state_d            = ST_EVICT;
				end else if (i_q == LAST_IDX) begin
					fin = 1'b1;
				end else begin
					i_d        = i_q + 1'b1;
					mreq.re    = 1'b1;
					mreq.raddr = i_q + 1'b1;
				end
			end

			ST_EVICT: begin
				// move the last entry into the victim's slot
				mreq.we    = 1'b1;
				mreq.waddr = victim_q;
				mreq.wdata = rdata;
				state_d    = ST_APPEND;
			end

			ST_APPEND: begin
				mreq.we         = 1'b1;
				mreq.waddr      = LAST_IDX;
				mreq.wdata      = new_entry;
				work_d.accepted = 1'b1;
				fin             = 1'b1;
			end

			ST_REMOVE: begin
				mreq.we    = 1'b1;
				mreq.waddr = IDX_W'(cmd_q.slot);
				mreq.wdata = rdata;
				count_d    = count_q - 1'b1;
				fin        = 1'b1;
			end

			ST_TICK: begin
				// rdata is the entry now standing at slot i_q
				if (!alu_zero) begin
					mreq.we    = 1'b1;
					mreq.waddr = i_q;
					mreq.wdata = '{priority_v: rdata.priority_v,
					               lifetime:   alu_diff,
					               tag:        rdata.tag};
					if (32'(i_q) + 1 < 32'(count_q)) begin
						i_d        = i_q + 1'b1;
						mreq.re    = 1'b1;
						mreq.raddr = i_q + 1'b1;
					end else begin
						fin = 1'b1;
					end
				end else begin
					// expired: drop it, pull in the last entry and tick that at the same slot
					work_d.expired_count = work_q.expired_count + 1'b1;
					count_d              = count_q - 1'b1;
					if (i_q == last) begin
						fin = 1'b1;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = last;
					end
				end
			end

			ST_READ: begin
				work_d.read_valid    = 1'b1;
				work_d.read_priority = rdata.priority_v;
				work_d.read_lifetime = rdata.lifetime;
				work_d.read_tag      = rdata.tag;
				fin                  = 1'b1;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = ST_IDLE;
		end

		// the live count always travels with the result word
		work_d.count_after = RCNT_W'(count_d);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	// payload: hold the command word, advance the cursor, latch the result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		i_q      <= i_d;
		victim_q <= victim_d;
		work_q   <= work_d;
		if (fin) begin
			result_q <= work_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
